@@ rtl/assert_macros.svh @@
// Assertion macros used by euler_to_quaternion_top.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ rtl/e2q_pkg.sv @@
// Types and constants for the Euler angle to quaternion datapath.
// No dependencies; used by e2q_trig and euler_to_quaternion_top.
package e2q_pkg;

   // trig polynomial arithmetic
   localparam int FRAC    = 46;           // fraction bits of polynomial values
   localparam int PW      = 48;           // polynomial accumulator width
   localparam int HALF_W  = PW / 2;       // split point for partial products
   localparam int UW      = 15;           // reduced angle, Q0.14, up to 1.0
   localparam int VW      = 29;           // reduced angle squared, Q0.28
   localparam int VFRAC   = 2 * (UW - 1);
   localparam int PROD_W  = HALF_W + VW;
   localparam int NSTEP   = 7;            // Horner steps per sine / cosine
   localparam int TRIG_LAT = 2 * NSTEP + 5;
   localparam int QW      = 16;

   // Taylor coefficients of sin/cos(u*pi/4), worked out at 96 fraction bits
   localparam int CONST_FRAC = 96;
   localparam logic [191:0] PI4    = 192'hC90FDAA22168C234C4C6628B;
   localparam logic [191:0] PI4_SQ = (PI4 * PI4) >> CONST_FRAC;
   localparam logic [191:0] SA1  = PI4;
   localparam logic [191:0] SA3  = ((SA1  * PI4_SQ) >> CONST_FRAC) / 6;
   localparam logic [191:0] SA5  = ((SA3  * PI4_SQ) >> CONST_FRAC) / 20;
   localparam logic [191:0] SA7  = ((SA5  * PI4_SQ) >> CONST_FRAC) / 42;
   localparam logic [191:0] SA9  = ((SA7  * PI4_SQ) >> CONST_FRAC) / 72;
   localparam logic [191:0] SA11 = ((SA9  * PI4_SQ) >> CONST_FRAC) / 110;
   localparam logic [191:0] SA13 = ((SA11 * PI4_SQ) >> CONST_FRAC) / 156;
   localparam logic [191:0] SA15 = ((SA13 * PI4_SQ) >> CONST_FRAC) / 210;
   localparam logic [191:0] CB0  = 192'd1 << CONST_FRAC;
   localparam logic [191:0] CB2  = PI4_SQ / 2;
   localparam logic [191:0] CB4  = ((CB2  * PI4_SQ) >> CONST_FRAC) / 12;
   localparam logic [191:0] CB6  = ((CB4  * PI4_SQ) >> CONST_FRAC) / 30;
   localparam logic [191:0] CB8  = ((CB6  * PI4_SQ) >> CONST_FRAC) / 56;
   localparam logic [191:0] CB10 = ((CB8  * PI4_SQ) >> CONST_FRAC) / 90;
   localparam logic [191:0] CB12 = ((CB10 * PI4_SQ) >> CONST_FRAC) / 132;
   localparam logic [191:0] CB14 = ((CB12 * PI4_SQ) >> CONST_FRAC) / 182;

   function automatic logic [PW-1:0] to_coef(input logic [191:0] a);
      logic [191:0] r;
      r = (a + (192'd1 << (CONST_FRAC - FRAC - 1))) >> (CONST_FRAC - FRAC);
      return r[PW-1:0];
   endfunction

   // magnitudes; signs alternate and are applied by subtraction in Horner
   localparam logic [PW-1:0] SIN_COEF [NSTEP+1] = '{
      to_coef(SA1), to_coef(SA3), to_coef(SA5), to_coef(SA7),
      to_coef(SA9), to_coef(SA11), to_coef(SA13), to_coef(SA15)};
   localparam logic [PW-1:0] COS_COEF [NSTEP+1] = '{
      to_coef(CB0), to_coef(CB2), to_coef(CB4), to_coef(CB6),
      to_coef(CB8), to_coef(CB10), to_coef(CB12), to_coef(CB14)};

   typedef struct packed {
      logic [VW-1:0] v;
      logic [UW-1:0] u;
      logic          neg;
      logic          swap;
   } trig_side_type;

   typedef struct packed {
      logic signed [QW-1:0] w;
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
   } quat_type;

endpackage

@@ rtl/e2q_trig.sv @@
// Pipelined sine and cosine of half a 16-bit binary angle, scaled to 32767.
// Depends on e2q_pkg; instantiated three times by euler_to_quaternion_top.
module e2q_trig (
   input  logic                         clock,
   input  logic                         en,
   input  logic [15:0]                  angle,
   output logic signed [e2q_pkg::QW-1:0] sin_q,
   output logic signed [e2q_pkg::QW-1:0] cos_q
);

   localparam int NSTEP  = e2q_pkg::NSTEP;
   localparam int PW     = e2q_pkg::PW;
   localparam int HW     = e2q_pkg::HALF_W;
   localparam int UW     = e2q_pkg::UW;
   localparam int VW     = e2q_pkg::VW;
   localparam int PRW    = e2q_pkg::PROD_W;
   localparam int SIDE_N = 2 * NSTEP + 3;
   localparam int SPW    = PW + UW;
   localparam logic [15:0] MAG_QUARTER = 16'd16384;
   localparam logic [15:0] MAG_HALF    = 16'd32768;

   // c - p*v, p*v given as two partial products
   function automatic logic [PW-1:0] horner(input logic [PW-1:0] c,
                                            input logic [PRW-1:0] hi,
                                            input logic [PRW-1:0] lo);
      logic [PRW+HW-1:0] acc;
      logic [PRW+HW-1:0] shr;
      acc = {hi, {HW{1'b0}}} + {{HW{1'b0}}, lo};
      shr = acc >> e2q_pkg::VFRAC;
      return c - shr[PW-1:0];
   endfunction

   // round(32767 * x) for x in Q.46, 0 <= x <= 1
   function automatic logic [UW-1:0] scale_round(input logic [PW-1:0] x);
      logic [PW+UW-1:0] t;
      t = {x, {UW{1'b0}}} - {{UW{1'b0}}, x};
      t = t + ((PW+UW)'(1) << (e2q_pkg::FRAC - 1));
      return t[e2q_pkg::FRAC+UW-1:e2q_pkg::FRAC];
   endfunction

   logic [15:0]            mag;
   logic                   neg;
   logic                   swap;
   logic [UW-1:0]          r0_ff;
   logic                   neg0_ff;
   logic                   swap0_ff;
   e2q_pkg::trig_side_type side_ff [SIDE_N];
   logic [PRW-1:0]         sh_ff [NSTEP];
   logic [PRW-1:0]         sl_ff [NSTEP];
   logic [PRW-1:0]         ch_ff [NSTEP];
   logic [PRW-1:0]         cl_ff [NSTEP];
   logic [PW-1:0]          ps_ff [NSTEP];
   logic [PW-1:0]          pc_ff [NSTEP];
   logic [SPW-1:0]         sin_prod_ff;
   logic [PW-1:0]          cos_f1_ff;
   logic [UW-1:0]          smag_ff;
   logic [UW-1:0]          cmag_ff;
   logic [UW-1:0]          sel_s;
   logic [UW-1:0]          sel_c;
   logic signed [15:0]     sin_ff;
   logic signed [15:0]     cos_ff;

   // fold the half angle into [0, pi/4]; beyond that sine and cosine trade places
   always_comb begin
      neg  = angle[15];
      mag  = neg ? 16'(~angle + 16'd1) : angle;
      swap = mag > MAG_QUARTER;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff    <= swap ? UW'(MAG_HALF - mag) : UW'(mag);
         neg0_ff  <= neg;
         swap0_ff <= swap;
         side_ff[0] <= '{v: VW'({{UW{1'b0}}, r0_ff} * {{UW{1'b0}}, r0_ff}),
                         u: r0_ff, neg: neg0_ff, swap: swap0_ff};
         for (int i = 1; i < SIDE_N; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   genvar j;
   for (j = 0; j < NSTEP; j++) begin : g_step
      logic [PW-1:0] ps_prev;
      logic [PW-1:0] pc_prev;
      if (j == 0) begin : g_first
         assign ps_prev = e2q_pkg::SIN_COEF[NSTEP];
         assign pc_prev = e2q_pkg::COS_COEF[NSTEP];
      end else begin : g_rest
         assign ps_prev = ps_ff[j-1];
         assign pc_prev = pc_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sh_ff[j] <= PRW'(ps_prev[PW-1:HW]) * PRW'(side_ff[2*j].v);
            sl_ff[j] <= PRW'(ps_prev[HW-1:0])  * PRW'(side_ff[2*j].v);
            ch_ff[j] <= PRW'(pc_prev[PW-1:HW]) * PRW'(side_ff[2*j].v);
            cl_ff[j] <= PRW'(pc_prev[HW-1:0])  * PRW'(side_ff[2*j].v);
            ps_ff[j] <= horner(e2q_pkg::SIN_COEF[NSTEP-1-j], sh_ff[j], sl_ff[j]);
            pc_ff[j] <= horner(e2q_pkg::COS_COEF[NSTEP-1-j], ch_ff[j], cl_ff[j]);
         end
      end
   end

   always_comb begin
      sel_s = side_ff[SIDE_N-1].swap ? cmag_ff : smag_ff;
      sel_c = side_ff[SIDE_N-1].swap ? smag_ff : cmag_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // odd polynomial: one more factor of u
         sin_prod_ff <= SPW'(ps_ff[NSTEP-1]) * SPW'(side_ff[2*NSTEP].u);
         cos_f1_ff   <= pc_ff[NSTEP-1];
         smag_ff     <= scale_round(PW'(sin_prod_ff >> (UW - 1)));
         cmag_ff     <= scale_round(cos_f1_ff);
         sin_ff      <= side_ff[SIDE_N-1].neg ? -$signed({1'b0, sel_s})
                                              : $signed({1'b0, sel_s});
         cos_ff      <= $signed({1'b0, sel_c});
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

@@ rtl/euler_to_quaternion_top.sv @@
// Euler angles (Z-Y-X) to unit quaternion, Q1.15, fully pipelined.
// Path to rsp_valid: trig pipelines, pair products, rounding, times pitch, output buffer.
// Throughput: one per cycle unless back-pressure fills the 2-entry output buffer.
// Reset (synchronous, active high) clears the stage valid bits and output buffer valid bits.
// Depends on e2q_pkg, e2q_trig and assert_macros.svh.
`include "assert_macros.svh"

module euler_to_quaternion_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);

   localparam int QW       = e2q_pkg::QW;
   localparam int MW       = 2 * QW;
   localparam int PIPE_LEN = e2q_pkg::TRIG_LAT + 3;

   // Q1.15 product rounded to nearest, ties up
   function automatic logic signed [QW-1:0] qround(input logic signed [MW-1:0] p);
      logic signed [MW-1:0] n;
      n = p + MW'(32'sd16384);
      return QW'(n >>> (QW - 1));
   endfunction

   function automatic logic signed [QW-1:0] sat16(input logic signed [QW:0] s);
      logic signed [QW-1:0] r;
      if (s > $signed({2'b00, {(QW-1){1'b1}}})) begin
         r = {1'b0, {(QW-1){1'b1}}};
      end else if (s < $signed({2'b11, {(QW-1){1'b0}}})) begin
         r = {1'b1, {(QW-1){1'b0}}};
      end else begin
         r = s[QW-1:0];
      end
      return r;
   endfunction

   logic                 adv;
   logic                 push;
   logic                 head_take;
   logic [PIPE_LEN-1:0]  vld_ff;
   logic signed [QW-1:0] sr, cr, sp, cp, sy, cy;

   logic signed [MW-1:0] cycr_ff, sysr_ff, cysr_ff, sycr_ff;
   logic signed [QW-1:0] cp1_ff, sp1_ff;
   logic signed [QW-1:0] cycr2_ff, sysr2_ff, cysr2_ff, sycr2_ff;
   logic signed [QW-1:0] cp2_ff, sp2_ff;
   logic signed [MW-1:0] wa_ff, wb_ff, xa_ff, xb_ff, ya_ff, yb_ff, za_ff, zb_ff;

   e2q_pkg::quat_type push_q;
   e2q_pkg::quat_type head_ff, head_in;
   e2q_pkg::quat_type spare_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              spare_vld_ff, spare_vld_in;

   // the whole pipeline moves unless the output buffer is full
   assign adv       = !(rsp_valid_ff && spare_vld_ff);
   assign req_ready = adv;
   assign push      = adv && vld_ff[PIPE_LEN-1];

   e2q_trig u_roll (
      .clock (clock), .en (adv), .angle (req_roll_angle), .sin_q (sr), .cos_q (cr));
   e2q_trig u_pitch (
      .clock (clock), .en (adv), .angle (req_pitch_angle), .sin_q (sp), .cos_q (cp));
   e2q_trig u_yaw (
      .clock (clock), .en (adv), .angle (req_yaw_angle), .sin_q (sy), .cos_q (cy));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // yaw/roll pair products
         cycr_ff  <= cy * cr;
         sysr_ff  <= sy * sr;
         cysr_ff  <= cy * sr;
         sycr_ff  <= sy * cr;
         cp1_ff   <= cp;
         sp1_ff   <= sp;
         cycr2_ff <= qround(cycr_ff);
         sysr2_ff <= qround(sysr_ff);
         cysr2_ff <= qround(cysr_ff);
         sycr2_ff <= qround(sycr_ff);
         cp2_ff   <= cp1_ff;
         sp2_ff   <= sp1_ff;
         // times pitch
         wa_ff    <= cycr2_ff * cp2_ff;
         wb_ff    <= sysr2_ff * sp2_ff;
         xa_ff    <= cysr2_ff * cp2_ff;
         xb_ff    <= sycr2_ff * sp2_ff;
         ya_ff    <= cycr2_ff * sp2_ff;
         yb_ff    <= sysr2_ff * cp2_ff;
         za_ff    <= sycr2_ff * cp2_ff;
         zb_ff    <= cysr2_ff * sp2_ff;
      end
   end

   always_comb begin
      push_q.w = sat16((QW+1)'(qround(wa_ff)) + (QW+1)'(qround(wb_ff)));
      push_q.x = sat16((QW+1)'(qround(xa_ff)) - (QW+1)'(qround(xb_ff)));
      push_q.y = sat16((QW+1)'(qround(ya_ff)) + (QW+1)'(qround(yb_ff)));
      push_q.z = sat16((QW+1)'(qround(za_ff)) - (QW+1)'(qround(zb_ff)));
   end

   // two-entry output buffer: head drives the rsp ports, spare catches one more
   always_comb begin
      head_take    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = head_take ? (spare_vld_ff || push) : 1'b1;
      spare_vld_in = head_take ? (spare_vld_ff && push) : (spare_vld_ff || push);
      head_in      = head_ff;
      if (head_take) begin
         head_in = spare_vld_ff ? spare_ff : push_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         spare_vld_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         spare_vld_ff <= spare_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (push) begin
         spare_ff <= push_q;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = head_ff.w;
   assign rsp_quat_x = head_ff.x;
   assign rsp_quat_y = head_ff.y;
   assign rsp_quat_z = head_ff.z;

   `ASSERT_IMPLY(a_no_overflow, clock, reset, push, !(rsp_valid_ff && spare_vld_ff))
   `ASSERT_IMPLY(a_spare_behind_head, clock, reset, spare_vld_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_spare_fill_on_stall, clock, reset, rsp_valid_ff && !rsp_ready && push, spare_vld_ff)

endmodule
